// ===== rtl/mbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbsp_pkg
// Shared types, constants and the status length table for the MIDI byte
// stream message parser.
// ----------------------------------------------------------------------------
package mbsp_pkg;

    localparam logic [7:0] STATUS_MASK    = 8'h80;
    localparam logic [7:0] ACTIVE_SENSING = 8'hFE;

    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [3:0] cable;
        logic [1:0] msg_len;
        logic [7:0] status_out;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic       forwarded;
        logic       activity;
    } msg_t;

    function automatic logic [1:0] table_length(input logic [7:0] st);
        logic [1:0] len;
        len = LEN_NONE;
        case (st[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = LEN_THREE;
            4'hC, 4'hD:                   len = LEN_TWO;
            4'hF:
            begin
                case (st[3:0])
                    4'h1, 4'h3:                               len = LEN_TWO;
                    4'h2:                                     len = LEN_THREE;
                    4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE, 4'hF: len = LEN_ONE;
                    default:                                  len = LEN_NONE;
                endcase
            end
            default: len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/mbsp_if.sv =====
// ----------------------------------------------------------------------------
// mbsp_if
// Valid/ready channels: received byte stream and completed message stream.
// ----------------------------------------------------------------------------
interface mbsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbsp_msg_if;
    logic       valid;
    logic       ready;
    logic [3:0] cable;
    logic [1:0] msg_len;
    logic [7:0] status_out;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic       forwarded;
    logic       activity;

    modport source (output valid, output cable, output msg_len, output status_out,
                    output data_first, output data_second, output forwarded,
                    output activity, input ready);
    modport sink   (input valid, input cable, input msg_len, input status_out,
                    input data_first, input data_second, input forwarded,
                    input activity, output ready);
endinterface

// ===== rtl/mbsp_parser.sv =====
// ----------------------------------------------------------------------------
// mbsp_parser
// Input byte register, running status parse state and message assembly.
// ----------------------------------------------------------------------------
module mbsp_parser (
    input  logic                clk,
    input  logic                rst_n,
    mbsp_byte_if.sink           rx,
    input  logic [3:0]          cable_number,
    input  logic                out_free,
    output logic                load,
    output mbsp_pkg::msg_t      msg
);
    import mbsp_pkg::*;

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] rs_reg, rs_next;
    logic [1:0] len_reg, len_next;
    logic [7:0] held_reg, held_next;
    logic       act_reg, act_next;
    logic       in_v_reg;
    logic [7:0] byte_reg;
    logic       done;
    logic       advance;
    logic       rx_fire;
    msg_t       m;

    always_comb
    begin
        phase_next = phase_reg;
        rs_next    = rs_reg;
        len_next   = len_reg;
        held_next  = held_reg;
        act_next   = act_reg;
        done       = 1'b0;
        m          = '0;
        case (phase_reg)
            PH_FIRST:
            begin
                held_next = byte_reg;
                if (len_reg == LEN_TWO)
                begin
                    done         = 1'b1;
                    m.msg_len    = LEN_TWO;
                    m.status_out = rs_reg;
                    m.data_first = byte_reg;
                end
                else
                begin
                    phase_next = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                done          = 1'b1;
                m.msg_len     = LEN_THREE;
                m.status_out  = rs_reg;
                m.data_first  = held_reg;
                m.data_second = byte_reg;
            end
            default:
            begin
                if ((byte_reg & STATUS_MASK) == 8'h00)
                begin
                    if (len_reg == LEN_TWO)
                    begin
                        done         = 1'b1;
                        m.msg_len    = LEN_TWO;
                        m.status_out = rs_reg;
                        m.data_first = byte_reg;
                    end
                    else
                    begin
                        held_next  = byte_reg;
                        phase_next = PH_SECOND;
                    end
                end
                else
                begin
                    rs_next  = byte_reg;
                    len_next = table_length(byte_reg);
                    if (len_next == LEN_ONE)
                    begin
                        done         = 1'b1;
                        m.msg_len    = LEN_ONE;
                        m.status_out = byte_reg;
                    end
                    else
                    begin
                        phase_next = PH_FIRST;
                    end
                end
            end
        endcase
        if (done)
        begin
            act_next   = ~act_reg;
            phase_next = PH_STATUS;
        end
        m.cable     = cable_number;
        m.forwarded = (m.status_out != ACTIVE_SENSING);
        m.activity  = act_next;
    end

    assign advance  = in_v_reg && (out_free || !done);
    assign rx.ready = !in_v_reg || advance;
    assign rx_fire  = rx.valid && rx.ready;
    assign load     = advance && done;
    assign msg      = m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STATUS;
            rs_reg    <= 8'h00;
            len_reg   <= LEN_NONE;
            held_reg  <= 8'h00;
            act_reg   <= 1'b1;
            in_v_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                rs_reg    <= rs_next;
                len_reg   <= len_next;
                held_reg  <= held_next;
                act_reg   <= act_next;
            end
            if (rx_fire)
                in_v_reg <= 1'b1;
            else if (advance)
                in_v_reg <= 1'b0;
        end
    end

    // hold the byte until it is consumed
    always_ff @(posedge clk)
    begin
        if (rx_fire)
            byte_reg <= rx.rx_byte;
    end

`ifndef NO_ASSERTIONS
    a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> act_reg != $past(act_reg))
        else $error("activity did not toggle on completion");
    a_first_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FIRST |-> len_reg != LEN_ONE)
        else $error("data phase entered for one-byte status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && !advance |=> in_v_reg && $stable(byte_reg))
        else $error("pending byte lost");
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(act_reg))
        else $error("parse state moved without consuming a byte");
`endif

endmodule

// ===== rtl/mbsp_out_reg.sv =====
// ----------------------------------------------------------------------------
// mbsp_out_reg
// Result register driving the completed message channel.
// ----------------------------------------------------------------------------
module mbsp_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mbsp_pkg::msg_t      msg,
    output logic                out_free,
    mbsp_msg_if.source          out
);
    import mbsp_pkg::*;

    logic v_reg;
    msg_t msg_reg;

    assign out_free = !v_reg || out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (load)
            v_reg <= 1'b1;
        else if (out.ready)
            v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            msg_reg <= msg;
    end

    assign out.valid       = v_reg;
    assign out.cable       = msg_reg.cable;
    assign out.msg_len     = msg_reg.msg_len;
    assign out.status_out  = msg_reg.status_out;
    assign out.data_first  = msg_reg.data_first;
    assign out.data_second = msg_reg.data_second;
    assign out.forwarded   = msg_reg.forwarded;
    assign out.activity    = msg_reg.activity;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !v_reg || out.ready)
        else $error("pending transfer overwritten");
    a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |-> msg_reg.forwarded == (msg_reg.status_out != ACTIVE_SENSING))
        else $error("forwarded flag mismatch");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |-> msg_reg.msg_len != LEN_NONE)
        else $error("empty message presented");
`endif

endmodule

// ===== rtl/midi_byte_stream_message_parser_core.sv =====
// The rx byte that completes a message is captured in the input byte register;
// the message then loads into the result register, when it is free, and is valid on msg.
// Throughput: one byte per cycle; while a message waits on msg, a byte that
// completes the next one holds in the input register and stalls rx.
// Reset: rst_n clears the parse state, running status, cable number and
// activity level (set to 1) at once; no clearing pass.
// ----------------------------------------------------------------------------
// midi_byte_stream_message_parser_core
// MIDI 1.0 byte stream parser with running status, top level.
// ----------------------------------------------------------------------------
module midi_byte_stream_message_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    mbsp_byte_if.sink   rx,
    mbsp_msg_if.source  msg,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata
);
    import mbsp_pkg::*;

    logic [3:0] cable_reg;
    logic       out_free;
    logic       load;
    msg_t       result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cable_reg <= 4'h0;
        else if (cfg_we)
            cable_reg <= cfg_wdata;
    end

    mbsp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (rx),
        .cable_number (cable_reg),
        .out_free     (out_free),
        .load         (load),
        .msg          (result)
    );

    mbsp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .msg      (result),
        .out_free (out_free),
        .out      (msg)
    );

endmodule
